// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define MRT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrt assertion failed");

// Next-cycle implication, quiet while reset is high.
`define MRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrt assertion failed");

`endif

// ===== hdl/mrt_pkg.sv =====
// Shared widths, codes and controller/datapath interface types.
`default_nettype none
package mrt_pkg;

  localparam int ADDR_W          = 48;
  localparam int LEN_W           = 49;
  localparam int SLOT_W          = 4;
  localparam int REQ_W           = 2;
  localparam int STAT_W          = 2;
  localparam int IN_DATA_W       = 104;
  localparam int OUT_DATA_W      = 104;
  localparam int MAX_REGIONS_DEF = 16;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_UNUSED    = 2'd3;

  typedef struct packed {
    logic start;    // latch request, rewind scan
    logic issue;    // read next slot
    logic capture;  // hold the scan result
    logic commit;   // update table, load output word
  } mrt_cmd_t;

  typedef struct packed {
    logic rd_vld;    // slot read data present
    logic rd_hit;    // that slot is free (insert) or matches (lookup/remove)
    logic rd_last;   // that slot is the last one
    logic out_free;  // output register can take a word
  } mrt_stat_t;

endpackage
`default_nettype wire

// ===== hdl/mrt_ctrl.sv =====
// Controller state machine: accept, scan, commit.
`default_nettype none
module mrt_ctrl
  import mrt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mrt_stat_t stat,
  output mrt_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        // stop at the first hit or after the last slot
        if (stat.rd_vld && (stat.rd_hit || stat.rd_last)) begin
          cmd.capture = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/mrt_datapath.sv =====
// Datapath: request register, slot table, scan compare and output register.
`default_nettype none
module mrt_datapath
  import mrt_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [ADDR_W-1:0] in_addr,
  input  wire logic [LEN_W-1:0]  in_length,
  input  wire mrt_cmd_t          cmd,
  output mrt_stat_t              stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [ADDR_W-1:0]      out_start,
  output logic [LEN_W-1:0]       out_len
);

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_REGIONS - 1);

  // request
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] req_addr;
  logic [LEN_W-1:0]  req_len;

  // table
  logic [MAX_REGIONS-1:0] present;
  logic [ADDR_W-1:0]      mem_start [MAX_REGIONS];
  logic [LEN_W-1:0]       mem_len   [MAX_REGIONS];

  // scan
  logic [IW-1:0]     scan_idx;
  logic              issue_done;
  logic              issue_en;
  logic              rd_vld;
  logic [IW-1:0]     rd_idx;
  logic              rd_present;
  logic [ADDR_W-1:0] rd_start;
  logic [LEN_W-1:0]  rd_len;
  logic [ADDR_W+1:0] rd_end;
  logic              in_range;
  logic              rd_hit;

  // captured scan result
  logic              res_found;
  logic [IW-1:0]     res_idx;
  logic [ADDR_W-1:0] res_start;
  logic [LEN_W-1:0]  res_len;

  logic tbl_write;
  logic tbl_clear;

  assign issue_en = cmd.issue && !issue_done;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_type <= in_req_type;
      req_addr <= in_addr;
      req_len  <= in_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      rd_vld <= issue_en;
      if (cmd.start) begin
        scan_idx   <= '0;
        issue_done <= 1'b0;
      end else if (issue_en) begin
        if (scan_idx == LAST_IDX) begin
          issue_done <= 1'b1;
        end else begin
          scan_idx <= scan_idx + IW'(1);
        end
      end
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_write) begin
      mem_start[res_idx] <= req_addr;
      mem_len[res_idx]   <= req_len;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_en) begin
      rd_start   <= mem_start[scan_idx];
      rd_len     <= mem_len[scan_idx];
      rd_present <= present[scan_idx];
      rd_idx     <= scan_idx;
    end
  end

  // end of range, start plus length, one bit wider than the length
  assign rd_end   = {2'b00, rd_start} + {1'b0, rd_len};
  assign in_range = (req_addr >= rd_start) && ({2'b00, req_addr} < rd_end);

  always_comb begin
    unique case (req_type)
      REQ_INSERT: rd_hit = !rd_present;
      REQ_LOOKUP,
      REQ_REMOVE: rd_hit = rd_present && in_range;
      default:    rd_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_found <= rd_hit;
      res_idx   <= rd_idx;
      res_start <= rd_start;
      res_len   <= rd_len;
    end
  end

  assign tbl_write = cmd.commit && res_found && (req_type == REQ_INSERT);
  assign tbl_clear = cmd.commit && res_found && (req_type == REQ_REMOVE);

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (tbl_write) begin
      present[res_idx] <= 1'b1;
    end else if (tbl_clear) begin
      present[res_idx] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!res_found) begin
        out_status <= (req_type == REQ_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
        out_slot   <= '0;
        out_start  <= '0;
        out_len    <= '0;
      end else if (req_type == REQ_INSERT) begin
        out_status <= STAT_OK;
        out_slot   <= SLOT_W'(res_idx);
        out_start  <= req_addr;
        out_len    <= req_len;
      end else begin
        out_status <= STAT_OK;
        out_slot   <= SLOT_W'(res_idx);
        out_start  <= res_start;
        out_len    <= res_len;
      end
    end
  end

  assign stat.rd_vld   = rd_vld;
  assign stat.rd_hit   = rd_hit;
  assign stat.rd_last  = (rd_idx == LAST_IDX);
  assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== hdl/mapped_region_table_core.sv =====
// A request is latched on accept, then the table is scanned up to the slot where the scan
// stops (first free slot on insert, first matching slot on lookup or remove, or the last
// slot when nothing is found). One slot is read per cycle from the table memory. The
// block takes no new request until the result word is loaded into the output register.
// Reset (rst, synchronous) empties the table and drops any word in flight.
`default_nettype none
module mapped_region_table_core
  import mrt_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // addr[47:0], length[96:48], zero pad
  input  wire logic [REQ_W-1:0]      s_axis_tuser,  // req_type[1:0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // slot[3:0], region_start[51:4],
                                                    // region_len[100:52], zero pad
  output logic [STAT_W-1:0]          m_axis_tuser   // status[1:0]
);

  mrt_cmd_t          cmd;
  mrt_stat_t         stat;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [ADDR_W-1:0] out_start;
  logic [LEN_W-1:0]  out_len;

  mrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mrt_datapath #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_req_type (s_axis_tuser),
    .in_addr     (s_axis_tdata[ADDR_W-1:0]),
    .in_length   (s_axis_tdata[ADDR_W+LEN_W-1:ADDR_W]),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_status  (out_status),
    .out_slot    (out_slot),
    .out_start   (out_start),
    .out_len     (out_len)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - SLOT_W - ADDR_W - LEN_W){1'b0}},
                         out_len, out_start, out_slot};
  assign m_axis_tuser = out_status;

endmodule
`default_nettype wire

// ===== hdl/mrt_checker.sv =====
// Port-level checker for the region table core, with its bind.
`default_nettype none
`include "assert_macros.svh"
module mrt_checker
  import mrt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [STAT_W-1:0]     m_axis_tuser
);

  logic stalled;
  logic in_acc;
  logic miss;

  assign stalled = m_axis_tvalid && !m_axis_tready;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign miss    = m_axis_tvalid && (m_axis_tuser != STAT_OK);

  `MRT_ASSERT_NEXT(a_out_hold, clk, rst, stalled, m_axis_tvalid)
  `MRT_ASSERT_NEXT(a_out_stable, clk, rst, stalled, $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `MRT_ASSERT_NOW(a_status_code, clk, rst, m_axis_tvalid, m_axis_tuser != STAT_UNUSED)
  `MRT_ASSERT_NOW(a_miss_zero, clk, rst, miss, m_axis_tdata == '0)
  `MRT_ASSERT_NEXT(a_one_in_flight, clk, rst, in_acc, !s_axis_tready)

endmodule

bind mapped_region_table_core mrt_checker u_mrt_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for mapped_region_table_core: streams insert/lookup/remove words.
`timescale 1ns / 1ps
module tb;
  import mrt_pkg::*;

  localparam int MAX_REGIONS = MAX_REGIONS_DEF;
  localparam int N_RANDOM = 1900;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_TOP = {1'b1, {ADDR_W{1'b0}}};
  localparam int PAD_W = IN_DATA_W - ADDR_W - LEN_W;

  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  length;
  } region_req_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } region_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [REQ_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0] m_axis_tuser;

  // predicted table contents
  logic              map_present [MAX_REGIONS];
  logic [ADDR_W-1:0] map_start [MAX_REGIONS];
  logic [LEN_W-1:0]  map_len [MAX_REGIONS];

  region_req_t   pending_reqs[$];
  region_reply_t expected_replies[$];
  region_req_t   inserted_log[$];
  region_req_t   cur_req;

  int n_items = 0;
  int n_sent = 0;
  int n_replies = 0;
  int n_bad = 0;
  int in_gap = 0;
  int out_hold = 0;
  int quiet_cycles = 0;

  mapped_region_table_core #(.MAX_REGIONS(MAX_REGIONS)) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < MAX_REGIONS; i++) begin
      map_present[i] = 1'b0;
      map_start[i] = '0;
      map_len[i] = '0;
    end
  end

  // Scan the predicted table the way the block does and return the answer word.
  function automatic region_reply_t apply_request(region_req_t rq);
    region_reply_t rp;
    int hit;
    logic [ADDR_W+1:0] stop;
    rp.status = STAT_NOT_FOUND;
    rp.slot = '0;
    rp.start = '0;
    rp.len = '0;
    hit = -1;
    if (rq.kind == REQ_INSERT) begin
      for (int i = 0; i < MAX_REGIONS && hit < 0; i++)
        if (!map_present[i]) hit = i;
      if (hit < 0) begin
        rp.status = STAT_FULL;
      end else begin
        map_present[hit] = 1'b1;
        map_start[hit] = rq.addr;
        map_len[hit] = rq.length;
        rp.status = STAT_OK;
        rp.slot = SLOT_W'(hit);
        rp.start = rq.addr;
        rp.len = rq.length;
      end
    end else if (rq.kind == REQ_LOOKUP || rq.kind == REQ_REMOVE) begin
      for (int i = 0; i < MAX_REGIONS && hit < 0; i++) begin
        stop = {2'b00, map_start[i]} + {1'b0, map_len[i]};
        if (map_present[i] && rq.addr >= map_start[i] && {2'b00, rq.addr} < stop) hit = i;
      end
      if (hit >= 0) begin
        rp.status = STAT_OK;
        rp.slot = SLOT_W'(hit);
        rp.start = map_start[hit];
        rp.len = map_len[hit];
        if (rq.kind == REQ_REMOVE) map_present[hit] = 1'b0;
      end
    end
    return rp;
  endfunction

  task automatic push_req(logic [REQ_W-1:0] k, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] n);
    region_req_t rq;
    rq.kind = k;
    rq.addr = a;
    rq.length = n;
    pending_reqs.push_back(rq);
    n_items++;
    if (k == REQ_INSERT) begin
      inserted_log.push_back(rq);
      if (inserted_log.size() > 64) void'(inserted_log.pop_front());
    end
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[ADDR_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int w;
    w = $urandom_range(0, 99);
    if (w < 10) return '0;
    if (w < 50) return LEN_W'($urandom_range(1, 512));
    if (w < 80) return LEN_W'($urandom_range(1, 1 << 20));
    if (w < 96) return {1'b0, rand_addr()};
    return LEN_TOP;
  endfunction

  // Cluster starts near zero, near 0x4000_0000 and the top so regions overlap often.
  function automatic logic [ADDR_W-1:0] rand_start();
    case ($urandom_range(0, 4))
      0: return ADDR_W'($urandom_range(0, 8191));
      1: return 48'h0000_4000_0000 + ADDR_W'($urandom_range(0, 8191));
      2: return ADDR_TOP - ADDR_W'($urandom_range(0, 8191));
      default: return rand_addr();
    endcase
  endfunction

  // Probe near the edges of regions inserted earlier, sometimes anywhere.
  function automatic logic [ADDR_W-1:0] rand_probe();
    region_req_t h;
    logic [ADDR_W+1:0] spot;
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    if (inserted_log.size() == 0 || $urandom_range(0, 7) == 0) return rand_start();
    h = inserted_log[$urandom_range(0, inserted_log.size() - 1)];
    case ($urandom_range(0, 4))
      0: spot = {2'b00, h.addr};
      1: spot = {2'b00, h.addr} + {1'b0, h.length} - (ADDR_W+2)'(1);
      2: spot = {2'b00, h.addr} + {1'b0, h.length};
      3: spot = {2'b00, h.addr} - (ADDR_W+2)'(1);
      default: spot = {2'b00, h.addr} +
                      ((h.length == 0) ? '0 : (ADDR_W+2)'(r % 64'(h.length)));
    endcase
    return spot[ADDR_W-1:0];
  endfunction

  function automatic int idle_draw(int count, int span, int phase);
    if ((count / span) % 3 == phase) return 0;
    return $urandom_range(0, 9);
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      n_bad++;
      if (n_bad <= 10)
        $display("mismatch on word %0d, %s: expected 0x%0h, got 0x%0h",
                 n_replies, name, want, got);
    end
  endtask

  initial begin
    logic [REQ_W-1:0] k;
    int w;
    // empty table, unknown request
    push_req(REQ_LOOKUP, ADDR_TOP, LEN_TOP);
    push_req(REQ_REMOVE, '0, '0);
    push_req(REQ_UNKNOWN, 48'h1234_5678_9abc, {1'b0, ADDR_TOP});
    // zero length region never matches
    push_req(REQ_INSERT, '0, '0);
    push_req(REQ_LOOKUP, '0, '0);
    // widest region at the top of the address space
    push_req(REQ_INSERT, ADDR_TOP, LEN_TOP);
    push_req(REQ_LOOKUP, ADDR_TOP, '0);
    // overlapping pair: lower slot wins
    push_req(REQ_INSERT, 48'h1000, 49'h100);
    push_req(REQ_INSERT, 48'h1080, 49'h100);
    push_req(REQ_LOOKUP, 48'h10ff, '0);
    push_req(REQ_LOOKUP, 48'h1180, '0);
    push_req(REQ_LOOKUP, 48'h0fff, '0);
    push_req(REQ_REMOVE, 48'h1090, '0);
    push_req(REQ_LOOKUP, 48'h1090, '0);
    // fill every free slot, then one more for the full answer
    for (int i = 0; i < MAX_REGIONS - 3; i++) push_req(REQ_INSERT, rand_start(), rand_len());
    push_req(REQ_INSERT, rand_start(), rand_len());

    // alternate fill-heavy and drain-heavy stretches so the table swings full and empty
    for (int i = 0; i < N_RANDOM; i++) begin
      w = $urandom_range(0, 99);
      if ((i / 120) % 2 == 0)
        k = (w < 50) ? REQ_INSERT : (w < 75) ? REQ_LOOKUP : (w < 95) ? REQ_REMOVE : REQ_UNKNOWN;
      else
        k = (w < 15) ? REQ_INSERT : (w < 45) ? REQ_LOOKUP : (w < 95) ? REQ_REMOVE : REQ_UNKNOWN;
      if (k == REQ_INSERT) push_req(k, rand_start(), rand_len());
      else if (k == REQ_UNKNOWN) push_req(k, rand_addr(), rand_len());
      else push_req(k, rand_probe(), rand_len());
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (n_sent < n_items || expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_bad == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Request driver: predict on accept, then present the next word after its gap.
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(apply_request(cur_req));
        n_sent++;
        offer = 1'b0;
        in_gap = idle_draw(n_sent, 40, 1);
      end
      if (!offer) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tdata <= {{PAD_W{1'b0}}, cur_req.length, cur_req.addr};
          s_axis_tuser <= cur_req.kind;
          offer = 1'b1;
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // Result monitor: compare each word with the oldest prediction, stall at random.
  always @(posedge clk) begin
    region_reply_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_replies++;
        if (expected_replies.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result word %0d: 0x%0h", n_replies, m_axis_tdata);
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 64'(want.status), 64'(m_axis_tuser));
          check_field("slot", 64'(want.slot), 64'(m_axis_tdata[SLOT_W-1:0]));
          check_field("region_start", 64'(want.start),
                      64'(m_axis_tdata[SLOT_W+ADDR_W-1:SLOT_W]));
          check_field("region_len", 64'(want.len),
                      64'(m_axis_tdata[SLOT_W+ADDR_W+LEN_W-1:SLOT_W+ADDR_W]));
        end
        out_hold = idle_draw(n_replies, 55, 2);
      end
      if (out_hold > 0) begin
        out_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: give up when neither side moves a word for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
